@@ design/smlc_pkg.sv @@
package smlc_pkg;

    // Input and output sample widths
    localparam int PSG_W    = 16;
    localparam int FM_W     = 18;
    localparam int GAIN_W   = 8;
    localparam int RANGE_W  = 7;
    localparam int OUT_W    = 16;

    // Scaled product: 18-bit sample times 8-bit gain, magnitude below 2^25
    localparam int PROD_W   = 26;
    localparam int DIVN_W   = 25;
    // Quotient of a 25-bit magnitude by 100 fits in 19 bits
    localparam int DIVQ_W   = 19;
    localparam int QUOT_W   = DIVQ_W + 1;
    localparam int MIX_W    = QUOT_W + 1;

    // Filter weight a = range * 65536 / 100 stays below 2^17
    localparam int WEIGHT_W = 17;
    localparam int ACC_W    = 32;
    localparam int FRAC_W   = 16;

    // Reciprocal of 100 scaled by 2^32, rounded up; exact for inputs below 2^25
    localparam int RECIP_SHIFT = 32;
    localparam int RECIP_W     = 26;
    localparam logic [RECIP_W-1:0] RECIP_100 = 26'd42949673;

    localparam logic [GAIN_W-1:0]   PSG_GAIN_RESET  = 8'd150;
    localparam logic [GAIN_W-1:0]   FM_GAIN_RESET   = 8'd100;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET    = 17'd32768;

    localparam logic signed [MIX_W-1:0] SAMPLE_MAX = 21'sd32767;
    localparam logic signed [MIX_W-1:0] SAMPLE_MIN = -21'sd32768;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PSG_GAIN  = 2'd0,
        CFG_FM_GAIN   = 2'd1,
        CFG_LP_ENABLE = 2'd2,
        CFG_LP_RANGE  = 2'd3
    } cfg_index_t;

    // Per-stage load strobes shared by the scaling units and the lanes
    typedef struct packed {
        logic ld_prod;
        logic ld_quot;
        logic ld_mix;
        logic ld_out;
    } pipe_ctrl_t;

    // Unsigned divide by 100 via reciprocal multiply
    function automatic logic [DIVQ_W-1:0] div100(input logic [DIVN_W-1:0] n);
        logic [DIVN_W+RECIP_W-1:0] prod;
        prod = n * RECIP_100;
        return prod[RECIP_SHIFT +: DIVQ_W];
    endfunction

endpackage

@@ design/smlc_scale.sv @@
// Percent gain: multiply by the gain, then divide by 100 truncating toward zero.
module smlc_scale
    import smlc_pkg::*;
(
    input  logic                     clk,
    input  pipe_ctrl_t               ctrl,
    input  logic signed [FM_W-1:0]   sample,
    input  logic [GAIN_W-1:0]        gain,
    output logic signed [QUOT_W-1:0] quot
);

    logic signed [PROD_W:0]   prod_full;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     neg;
    logic [PROD_W-1:0]        mag;
    logic [DIVQ_W-1:0]        q;
    logic signed [QUOT_W-1:0] quot_next;
    logic signed [QUOT_W-1:0] quot_reg;

    assign prod_full = sample * $signed({1'b0, gain});

    // Divide the magnitude, then restore the sign
    assign neg       = prod_reg[PROD_W-1];
    assign mag       = neg ? (-prod_reg) : prod_reg;
    assign q         = div100(mag[DIVN_W-1:0]);
    assign quot_next = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});

    always_ff @(posedge clk)
    begin
        if (ctrl.ld_prod)
        begin
            prod_reg <= prod_full[PROD_W-1:0];
        end
        if (ctrl.ld_quot)
        begin
            quot_reg <= quot_next;
        end
    end

    assign quot = quot_reg;

endmodule

@@ design/smlc_lane.sv @@
// One output channel: mix, then either a one-pole low-pass or a clip to 16 bits.
module smlc_lane
    import smlc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  pipe_ctrl_t               ctrl,
    input  logic signed [QUOT_W-1:0] psg_part,
    input  logic signed [QUOT_W-1:0] fm_part,
    input  logic                     lp_enable,
    input  logic [WEIGHT_W-1:0]      lp_weight,
    output logic signed [OUT_W-1:0]  sample
);

    logic signed [MIX_W-1:0]    mix_next;
    logic signed [MIX_W-1:0]    mix_reg;
    logic signed [MIX_W:0]      diff;
    logic signed [MIX_W+WEIGHT_W+1:0] prod;
    logic [ACC_W-1:0]           acc_next;
    logic [ACC_W-1:0]           acc_reg;
    logic signed [OUT_W-1:0]    out_next;
    logic signed [OUT_W-1:0]    out_reg;

    assign mix_next = MIX_W'(psg_part) + MIX_W'(fm_part);

    // (hi - x) * a + x * 2^16 equals hi * a + x * (2^16 - a) modulo 2^32
    assign diff     = (MIX_W+1)'($signed(acc_reg[ACC_W-1 -: OUT_W])) - (MIX_W+1)'(mix_reg);
    assign prod     = diff * $signed({1'b0, lp_weight});
    assign acc_next = prod[ACC_W-1:0] + {mix_reg[FRAC_W-1:0], {FRAC_W{1'b0}}};

    always_comb
    begin
        if (lp_enable)
        begin
            out_next = $signed(acc_next[ACC_W-1 -: OUT_W]);
        end
        else if (mix_reg > SAMPLE_MAX)
        begin
            out_next = SAMPLE_MAX[OUT_W-1:0];
        end
        else if (mix_reg < SAMPLE_MIN)
        begin
            out_next = SAMPLE_MIN[OUT_W-1:0];
        end
        else
        begin
            out_next = mix_reg[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.ld_out && lp_enable)
        begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld_mix)
        begin
            mix_reg <= mix_next;
        end
        if (ctrl.ld_out)
        begin
            out_reg <= out_next;
        end
    end

    assign sample = out_reg;

endmodule

@@ design/stereo_mixer_lowpass_clip_top.sv @@
// An accepted item passes the product, quotient, mix and output registers on its way to m_tdata.
// Throughput: one item per cycle while m_tready is high; each stage holds while the next
// one is full and stalled, so an item is still taken while a result waits, if any stage is empty.
// The filter recurrence closes in the last stage, one multiply and add per item.
// Reset (rst_n low, asynchronous): pipeline empty, filter accumulators zero,
// gains 150 % (PSG) and 100 % (FM), low-pass off, range 50 %.
module stereo_mixer_lowpass_clip_top
    import smlc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [55:0]           s_tdata,  // psg_sample[15:0], fm_left[33:16], fm_right[51:34]
    // Output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata   // out_left[15:0], out_right[31:16]
);

    // ------------------------------------------------------------------
    // Configuration registers. The filter weight a = range * 65536 / 100 is
    // worked out when the range is written, so the datapath never sees the range.
    // ------------------------------------------------------------------
    logic [GAIN_W-1:0]   psg_gain_reg;
    logic [GAIN_W-1:0]   fm_gain_reg;
    logic                lp_enable_reg;
    logic [WEIGHT_W-1:0] lp_weight_reg;
    logic [WEIGHT_W-1:0] lp_weight_next;
    logic [DIVQ_W-1:0]   weight_quot;

    assign weight_quot    = div100(DIVN_W'({cfg_data[RANGE_W-1:0], {FRAC_W{1'b0}}}));
    assign lp_weight_next = weight_quot[WEIGHT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            psg_gain_reg  <= PSG_GAIN_RESET;
            fm_gain_reg   <= FM_GAIN_RESET;
            lp_enable_reg <= 1'b0;
            lp_weight_reg <= WEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PSG_GAIN:  psg_gain_reg  <= cfg_data;
                CFG_FM_GAIN:   fm_gain_reg   <= cfg_data;
                CFG_LP_ENABLE: lp_enable_reg <= cfg_data[0];
                CFG_LP_RANGE:  lp_weight_reg <= lp_weight_next;
                default:       ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: four stages (product, quotient, mix, output).
    // A stage advances when the stage after it is empty or advancing itself.
    // ------------------------------------------------------------------
    logic       prod_vld_reg;
    logic       quot_vld_reg;
    logic       mix_vld_reg;
    logic       out_vld_reg;
    logic       out_rdy;
    logic       mix_rdy;
    logic       quot_rdy;
    logic       prod_rdy;
    pipe_ctrl_t ctrl;

    assign out_rdy  = !out_vld_reg  || m_tready;
    assign mix_rdy  = !mix_vld_reg  || out_rdy;
    assign quot_rdy = !quot_vld_reg || mix_rdy;
    assign prod_rdy = !prod_vld_reg || quot_rdy;

    assign ctrl.ld_prod = s_tvalid     && prod_rdy;
    assign ctrl.ld_quot = prod_vld_reg && quot_rdy;
    assign ctrl.ld_mix  = quot_vld_reg && mix_rdy;
    assign ctrl.ld_out  = mix_vld_reg  && out_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            quot_vld_reg <= 1'b0;
            mix_vld_reg  <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            // Fill on a load, drop once the item has moved on
            prod_vld_reg <= ctrl.ld_prod || (prod_vld_reg && !quot_rdy);
            quot_vld_reg <= ctrl.ld_quot || (quot_vld_reg && !mix_rdy);
            mix_vld_reg  <= ctrl.ld_mix  || (mix_vld_reg  && !out_rdy);
            out_vld_reg  <= ctrl.ld_out  || (out_vld_reg  && !m_tready);
        end
    end

    assign s_tready = prod_rdy;
    assign m_tvalid = out_vld_reg;

    // ------------------------------------------------------------------
    // Input unpacking and percent scaling: one unit for the PSG sample,
    // one per FM channel.
    // ------------------------------------------------------------------
    logic signed [PSG_W-1:0]  psg_sample;
    logic signed [FM_W-1:0]   fm_left;
    logic signed [FM_W-1:0]   fm_right;
    logic signed [QUOT_W-1:0] psg_part;
    logic signed [QUOT_W-1:0] fm_left_part;
    logic signed [QUOT_W-1:0] fm_right_part;

    assign psg_sample = s_tdata[PSG_W-1:0];
    assign fm_left    = s_tdata[PSG_W +: FM_W];
    assign fm_right   = s_tdata[PSG_W+FM_W +: FM_W];

    smlc_scale u_scale_psg
    (
        .clk    (clk),
        .ctrl   (ctrl),
        .sample (FM_W'(psg_sample)),
        .gain   (psg_gain_reg),
        .quot   (psg_part)
    );

    smlc_scale u_scale_left
    (
        .clk    (clk),
        .ctrl   (ctrl),
        .sample (fm_left),
        .gain   (fm_gain_reg),
        .quot   (fm_left_part)
    );

    smlc_scale u_scale_right
    (
        .clk    (clk),
        .ctrl   (ctrl),
        .sample (fm_right),
        .gain   (fm_gain_reg),
        .quot   (fm_right_part)
    );

    // ------------------------------------------------------------------
    // Channel lanes: each mixes in the shared PSG part, then filters or clips.
    // ------------------------------------------------------------------
    logic signed [OUT_W-1:0] out_left;
    logic signed [OUT_W-1:0] out_right;

    smlc_lane u_lane_left
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .psg_part  (psg_part),
        .fm_part   (fm_left_part),
        .lp_enable (lp_enable_reg),
        .lp_weight (lp_weight_reg),
        .sample    (out_left)
    );

    smlc_lane u_lane_right
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .psg_part  (psg_part),
        .fm_part   (fm_right_part),
        .lp_enable (lp_enable_reg),
        .lp_weight (lp_weight_reg),
        .sample    (out_right)
    );

    // Merge both lanes into one output item
    assign m_tdata = {out_right, out_left};

endmodule
